@@ hdl/rpmf_pkg.sv @@
// Shared types, constants and lookup tables for the RGB565 pixel mode filter.
// No dependencies; used by every other file of the block except rpmf_ram.
`default_nettype none

package rpmf_pkg;

   localparam int PIX_W  = 16;
   localparam int POS_W  = 9;
   localparam int LUMA_W = 8;
   localparam int THR_W  = 8;
   localparam int MODE_W = 2;

   localparam int DEF_MAX_WIDTH = 256;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH = 2'd3;

   // transform modes
   localparam logic [MODE_W-1:0] MODE_REDUCE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GRAY   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EDGE   = 2'd2;

   localparam logic [MODE_W-1:0] RST_MODE   = MODE_GRAY;
   localparam logic [POS_W-1:0]  RST_WIDTH  = 9'd20;
   localparam logic [POS_W-1:0]  RST_HEIGHT = 9'd15;
   localparam logic [THR_W-1:0]  RST_THRESH = 8'd48;

   localparam logic [PIX_W-1:0] PIX_WHITE = 16'hffff;
   localparam logic [PIX_W-1:0] PIX_BLACK = 16'h0000;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  width;
      logic [POS_W-1:0]  height;
      logic [THR_W-1:0]  threshold;
   } csr_type;

   // one accepted pixel on its way to the result register
   typedef struct packed {
      logic [PIX_W-1:0]  pix;
      logic [LUMA_W-1:0] luma;
      logic [LUMA_W-1:0] head_luma;
      logic              right_head;
      logic              last;
   } stage_type;

   typedef logic [31:0][7:0]  exp5_lut_type;
   typedef logic [63:0][7:0]  exp6_lut_type;
   typedef logic [255:0][4:0] gray5_lut_type;
   typedef logic [255:0][5:0] gray6_lut_type;

   function automatic exp5_lut_type build_exp5();
      exp5_lut_type t;
      for (int i = 0; i < 32; i++) t[i] = 8'((i * 255) / 31);
      return t;
   endfunction

   function automatic exp6_lut_type build_exp6();
      exp6_lut_type t;
      for (int i = 0; i < 64; i++) t[i] = 8'((i * 255) / 63);
      return t;
   endfunction

   function automatic gray5_lut_type build_gray5();
      gray5_lut_type t;
      for (int i = 0; i < 256; i++) t[i] = 5'((i * 31) / 255);
      return t;
   endfunction

   function automatic gray6_lut_type build_gray6();
      gray6_lut_type t;
      for (int i = 0; i < 256; i++) t[i] = 6'((i * 63) / 255);
      return t;
   endfunction

   localparam exp5_lut_type  EXP5_LUT  = build_exp5();
   localparam exp6_lut_type  EXP6_LUT  = build_exp6();
   localparam gray5_lut_type GRAY5_LUT = build_gray5();
   localparam gray6_lut_type GRAY6_LUT = build_gray6();

endpackage

`default_nettype wire

@@ hdl/rpmf_req_if.sv @@
// Input pixel channel: valid/ready handshake with RGB565 pixel and frame start.
// Depends on rpmf_pkg.
`default_nettype none

interface rpmf_req_if;
   logic                      valid;
   logic                      ready;
   logic [rpmf_pkg::PIX_W-1:0] pixel_in;
   logic                      frame_start;

   modport source (output valid, output pixel_in, output frame_start, input ready);
   modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

`default_nettype wire

@@ hdl/rpmf_rsp_if.sv @@
// Result pixel channel: valid/ready handshake with output pixel and frame end.
// Depends on rpmf_pkg.
`default_nettype none

interface rpmf_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rpmf_pkg::PIX_W-1:0] pixel_out;
   logic                      frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

@@ hdl/rgb565_pixel_mode_filter.sv @@
// RGB565 pixel mode filter: crop to multiples of 8, then reduced color, grayscale or edges.
// Depends on rpmf_pkg, rpmf_req_if, rpmf_rsp_if, rpmf_front, rpmf_back, rpmf_ram.
//
// Takes one pixel per clock on req_chan and, for pixels inside the crop, gives one result
// on rsp_chan through the registered read of the luminance line store (two copies, read
// at this column and the next), loaded alongside the staging register, and then the result
// register. A new pixel is taken in every cycle while rsp_chan keeps up; a stalled
// result holds one staged pixel before req_chan.ready drops. In edge mode row y is
// emitted while row y+1 arrives. The line store needs no clearing after reset.
`default_nettype none

module rgb565_pixel_mode_filter #(
   parameter int MAX_WIDTH = rpmf_pkg::DEF_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   rpmf_req_if.sink                        req_chan,
   rpmf_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [rpmf_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [rpmf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rpmf_pkg::*;

   csr_type             csr_ff, csr_in;
   logic                accept;
   logic                emit;
   logic                in_ready;
   stage_type           stage;
   logic [LUMA_W-1:0]   center_luma, right_luma;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_idx)
            CSR_MODE:   csr_in.mode      = csr_wdata[MODE_W-1:0];
            CSR_WIDTH:  csr_in.width     = csr_wdata[POS_W-1:0];
            CSR_HEIGHT: csr_in.height    = csr_wdata[POS_W-1:0];
            CSR_THRESH: csr_in.threshold = csr_wdata[THR_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.mode      <= RST_MODE;
         csr_ff.width     <= RST_WIDTH;
         csr_ff.height    <= RST_HEIGHT;
         csr_ff.threshold <= RST_THRESH;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign req_chan.ready = in_ready;
   assign accept         = req_chan.valid && in_ready;

   rpmf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .accept      (accept),
      .pixel_in    (req_chan.pixel_in),
      .frame_start (req_chan.frame_start),
      .emit        (emit),
      .stage       (stage),
      .center_luma (center_luma),
      .right_luma  (right_luma)
   );

   rpmf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .accept      (accept),
      .emit        (emit),
      .stage       (stage),
      .center_luma (center_luma),
      .right_luma  (right_luma),
      .in_ready    (in_ready),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .pixel_out   (rsp_chan.pixel_out),
      .frame_end   (rsp_chan.frame_end)
   );

endmodule

`default_nettype wire

@@ hdl/rpmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rpmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/rpmf_front.sv @@
// Input side: frame position tracking, crop decision, luminance and the line store.
// Depends on rpmf_pkg and rpmf_ram.
`default_nettype none

module rpmf_front #(
   parameter int MAX_WIDTH = rpmf_pkg::DEF_MAX_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rpmf_pkg::csr_type           csr,
   input  logic                        accept,
   input  logic [rpmf_pkg::PIX_W-1:0]  pixel_in,
   input  logic                        frame_start,
   output logic                        emit,
   output rpmf_pkg::stage_type         stage,
   output logic [rpmf_pkg::LUMA_W-1:0] center_luma,
   output logic [rpmf_pkg::LUMA_W-1:0] right_luma
);
   import rpmf_pkg::*;

   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [POS_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [LUMA_W-1:0] head_ff, head_in;
   logic [POS_W-1:0]  eff_w, eff_h, crop_w, crop_h, edge_h;
   logic [POS_W-1:0]  col, row;
   logic [POS_W:0]    col_inc, row_inc;
   logic              wrap_col, last_col, last;
   logic [7:0]        r8, g8, b8;
   logic [15:0]       luma_sum;
   logic [LUMA_W-1:0] luma;

   always_comb begin
      if (csr.width < POS_W'(8)) eff_w = POS_W'(8);
      else if (32'(csr.width) > MAX_WIDTH) eff_w = POS_W'(MAX_WIDTH);
      else eff_w = csr.width;
      eff_h  = (csr.height < POS_W'(8)) ? POS_W'(8) : csr.height;
      crop_w = {eff_w[POS_W-1:3], 3'b000};
      crop_h = {eff_h[POS_W-1:3], 3'b000};
      edge_h = (eff_h[2:0] != 3'b000) ? crop_h : crop_h - POS_W'(8);
   end

   // position of this pixel
   always_comb begin
      col = col_ff;
      row = row_ff;
      if (frame_start) begin
         col = '0;
         row = '0;
      end else begin
         if (col_ff >= eff_w) begin
            col = '0;
            row = row_ff + POS_W'(1);
         end
         if (row >= eff_h) row = '0;
      end
      col_inc  = {1'b0, col} + (POS_W+1)'(1);
      row_inc  = {1'b0, row} + (POS_W+1)'(1);
      wrap_col = col_inc >= {1'b0, eff_w};
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      head_in = head_ff;
      if (accept) begin
         if (wrap_col) begin
            col_in = '0;
            row_in = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[POS_W-1:0];
         end else begin
            col_in = col_inc[POS_W-1:0];
            row_in = row;
         end
         if (col == '0) head_in = luma;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         head_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         head_ff <= head_in;
      end
   end

   always_comb begin
      r8       = EXP5_LUT[pixel_in[15:11]];
      g8       = EXP6_LUT[pixel_in[10:5]];
      b8       = EXP5_LUT[pixel_in[4:0]];
      luma_sum = 16'(r8) * 16'd77 + 16'(g8) * 16'd150 + 16'(b8) * 16'd29;
      luma     = luma_sum[15:8];
   end

   always_comb begin
      last_col = col == crop_w - POS_W'(1);
      emit     = 1'b0;
      last     = 1'b0;
      case (csr.mode) inside
         MODE_REDUCE, MODE_GRAY: begin
            emit = (col < crop_w) && (row < crop_h);
            last = last_col && (row == crop_h - POS_W'(1));
         end
         MODE_EDGE: begin
            emit = (row != '0) && (col < crop_w) && (row - POS_W'(1) < edge_h);
            last = last_col && (row == edge_h);
         end
         default: begin
            emit = 1'b0;
            last = 1'b0;
         end
      endcase
   end

   always_comb begin
      stage.pix        = pixel_in;
      stage.luma       = luma;
      stage.head_luma  = head_ff;
      stage.right_head = wrap_col;
      stage.last       = last;
   end

   // two copies of the line: one read at this column, one at the next
   rpmf_ram #(.WIDTH(LUMA_W), .DEPTH(MAX_WIDTH)) u_line_center (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ADDR_W'(col)),
      .wr_data (luma),
      .rd_en   (accept),
      .rd_addr (ADDR_W'(col)),
      .rd_data (center_luma)
   );

   rpmf_ram #(.WIDTH(LUMA_W), .DEPTH(MAX_WIDTH)) u_line_right (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ADDR_W'(col)),
      .wr_data (luma),
      .rd_en   (accept),
      .rd_addr (ADDR_W'(col_inc)),
      .rd_data (right_luma)
   );

   a_frame_start_pos: assert property (@(posedge clock) disable iff (reset)
      accept && frame_start |=> (col_ff == POS_W'(1)) && (row_ff == '0))
      else $error("frame start did not restart position");

endmodule

`default_nettype wire

@@ hdl/rpmf_back.sv @@
// Output side: staging register, per-mode pixel transform and result register.
// Depends on rpmf_pkg.
`default_nettype none

module rpmf_back (
   input  logic                        clock,
   input  logic                        reset,
   input  rpmf_pkg::csr_type           csr,
   input  logic                        accept,
   input  logic                        emit,
   input  rpmf_pkg::stage_type         stage,
   input  logic [rpmf_pkg::LUMA_W-1:0] center_luma,
   input  logic [rpmf_pkg::LUMA_W-1:0] right_luma,
   output logic                        in_ready,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [rpmf_pkg::PIX_W-1:0]  pixel_out,
   output logic                        frame_end
);
   import rpmf_pkg::*;

   stage_type         s1_ff, s1_in;
   logic              s1_vld_ff, s1_vld_in;
   logic              out_vld_ff, out_vld_in;
   logic [PIX_W-1:0]  pix_out_ff, pix_out_in;
   logic              end_out_ff, end_out_in;
   logic              out_load;
   logic [4:0]        red_r, blu_r, gray_r;
   logic [5:0]        grn_r, gray_g;
   logic [LUMA_W-1:0] right, d_right, d_down;
   logic [LUMA_W:0]   grad;
   logic [PIX_W-1:0]  result;

   assign out_load = !out_vld_ff || out_ready;
   assign in_ready = !s1_vld_ff || out_load;

   always_comb begin
      s1_vld_in = accept ? emit : (s1_vld_ff && !out_load);
      s1_in     = accept ? stage : s1_ff;
   end

   always_comb begin
      // top two bits scaled by 9 and 17
      red_r  = {s1_ff.pix[15:14], 1'b0, s1_ff.pix[15:14]};
      grn_r  = {s1_ff.pix[10:9], 2'b00, s1_ff.pix[10:9]};
      blu_r  = {s1_ff.pix[4:3], 1'b0, s1_ff.pix[4:3]};
      gray_r = GRAY5_LUT[s1_ff.luma];
      gray_g = GRAY6_LUT[s1_ff.luma];

      right   = s1_ff.right_head ? s1_ff.head_luma : right_luma;
      d_right = (center_luma > right) ? center_luma - right : right - center_luma;
      d_down  = (center_luma > s1_ff.luma) ? center_luma - s1_ff.luma
                                           : s1_ff.luma - center_luma;
      grad    = {1'b0, d_right} + {1'b0, d_down};

      case (csr.mode)
         MODE_REDUCE: result = {red_r, grn_r, blu_r};
         MODE_GRAY:   result = {gray_r, gray_g, gray_r};
         MODE_EDGE:   result = (grad >= {1'b0, csr.threshold}) ? PIX_WHITE : PIX_BLACK;
         default:     result = PIX_BLACK;
      endcase
   end

   always_comb begin
      out_vld_in = out_load ? s1_vld_ff : out_vld_ff;
      pix_out_in = (out_load && s1_vld_ff) ? result : pix_out_ff;
      end_out_in = (out_load && s1_vld_ff) ? s1_ff.last : end_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff      <= s1_in;
      pix_out_ff <= pix_out_in;
      end_out_ff <= end_out_in;
   end

   assign out_valid = out_vld_ff;
   assign pixel_out = pix_out_ff;
   assign frame_end = end_out_ff;

   a_emit_staged: assert property (@(posedge clock) disable iff (reset)
      accept && emit |=> s1_vld_ff)
      else $error("emitting transfer not staged");

   a_out_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(s1_vld_ff))
      else $error("result appeared without a staged pixel");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !out_load |=> s1_vld_ff && $stable(s1_ff))
      else $error("staged pixel lost while result stalled");

endmodule

`default_nettype wire
